/* rtl/core/clipped_pixel_alpha_blend_defines.svh */
// Assertion macros for the clipped pixel alpha blend block.
// Every macro expects clk_i and rst_ni in the scope where it is used.
`ifndef CLIPPED_PIXEL_ALPHA_BLEND_DEFINES_SVH
`define CLIPPED_PIXEL_ALPHA_BLEND_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPAB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CPAB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/cpab_pkg.sv */
// Shared constants, types and register codes of the clipped pixel alpha blend block.
// No dependencies; every other source file but the assertion macro header imports it.
package cpab_pkg;

  localparam int unsigned MAX_WIDTH   = 128;
  localparam int unsigned MAX_HEIGHT  = 128;
  localparam int unsigned STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);

  localparam int unsigned PIXEL_W    = 24;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned NUM_CHAN   = 3;
  localparam int unsigned COORD_W    = 8;
  localparam int unsigned ALPHA_W    = 8;
  localparam int unsigned SURF_W     = 8;
  localparam int unsigned CLIP_W     = 9;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 9;

  localparam logic [ALPHA_W-1:0] FULL_ALPHA = 8'hFF;
  localparam logic [CHAN_W-1:0]  ROUND_HALF = 8'd127;

  typedef enum logic [0:0] {
    ACT_WRITE = 1'b0,
    ACT_READ  = 1'b1
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SURFACE_WIDTH  = 3'd0,
    CFG_SURFACE_HEIGHT = 3'd1,
    CFG_CLIP_LEFT      = 3'd2,
    CFG_CLIP_TOP       = 3'd3,
    CFG_CLIP_WIDTH     = 3'd4,
    CFG_CLIP_HEIGHT    = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [SURF_W-1:0]  surface_width;
    logic [SURF_W-1:0]  surface_height;
    logic [COORD_W-1:0] clip_left;
    logic [COORD_W-1:0] clip_top;
    logic [CLIP_W-1:0]  clip_width;
    logic [CLIP_W-1:0]  clip_height;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    surface_width:  8'd128,
    surface_height: 8'd128,
    clip_left:      8'd0,
    clip_top:       8'd0,
    clip_width:     9'd128,
    clip_height:    9'd128
  };

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the accepted request
    logic calc;    // work out address, surface and clip flags
    logic mem_rd;  // read the pixel under the request
    logic mix;     // form the weighted channel sums
    logic commit;  // write memory and load the result register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_read;
    logic need_blend;
  } dp_status_t;

endpackage

/* rtl/core/cpab_if.sv */
// Valid/ready channel interfaces: pixel requests, results and register writes.
// Depends on cpab_pkg for field widths.
interface cpab_req_if import cpab_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               action;
  logic [COORD_W-1:0] x_position;
  logic [COORD_W-1:0] y_position;
  logic [PIXEL_W-1:0] colour;
  logic [ALPHA_W-1:0] alpha;

  modport source (output valid, action, x_position, y_position, colour, alpha,
                  input ready);
  modport sink   (input valid, action, x_position, y_position, colour, alpha,
                  output ready);
endinterface

interface cpab_res_if import cpab_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel_value;
  logic               stored;

  modport source (output valid, pixel_value, stored, input ready);
  modport sink   (input valid, pixel_value, stored, output ready);
endinterface

interface cpab_cfg_if import cpab_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/cpab_cfg_regs.sv */
// Configuration registers for surface size and clip rectangle.
// Depends on cpab_pkg and the cpab_cfg_if interface.
module cpab_cfg_regs import cpab_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  cpab_cfg_if.sink   cfg_wr,
  output cfg_t       regs_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_wr.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr.valid) begin
      case (cfg_wr.index)
        CFG_SURFACE_WIDTH:  cfg_d.surface_width  = cfg_wr.data[SURF_W-1:0];
        CFG_SURFACE_HEIGHT: cfg_d.surface_height = cfg_wr.data[SURF_W-1:0];
        CFG_CLIP_LEFT:      cfg_d.clip_left      = cfg_wr.data[COORD_W-1:0];
        CFG_CLIP_TOP:       cfg_d.clip_top       = cfg_wr.data[COORD_W-1:0];
        CFG_CLIP_WIDTH:     cfg_d.clip_width     = cfg_wr.data[CLIP_W-1:0];
        CFG_CLIP_HEIGHT:    cfg_d.clip_height    = cfg_wr.data[CLIP_W-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign regs_o = cfg_q;

endmodule

/* rtl/core/cpab_ctrl.sv */
// Controller state machine: sequences one pixel request through the datapath.
// Depends on cpab_pkg for the command and status structs.
module cpab_ctrl import cpab_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_ADDR = 5'b00010,
    ST_READ = 5'b00100,
    ST_MIX  = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign req_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_ADDR;
        end
      end
      ST_ADDR: begin
        cmd_o.calc = 1'b1;
        state_d    = status_i.need_read ? ST_READ : ST_DONE;
      end
      ST_READ: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = status_i.need_blend ? ST_MIX : ST_DONE;
      end
      ST_MIX: begin
        cmd_o.mix = 1'b1;
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        // The result register may be reloaded in the cycle its content is taken.
        if (!out_valid_q || res_ready_i) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* rtl/core/cpab_datapath.sv */
// Datapath: request registers, address and clip checks, pixel memory,
// per-channel blend and the result register. Depends on cpab_pkg.
module cpab_datapath import cpab_pkg::*; (
  input  logic               clk_i,
  input  ctrl_cmd_t          cmd_i,
  input  cfg_t               cfg_i,
  input  logic               action_i,
  input  logic [COORD_W-1:0] x_position_i,
  input  logic [COORD_W-1:0] y_position_i,
  input  logic [PIXEL_W-1:0] colour_i,
  input  logic [ALPHA_W-1:0] alpha_i,
  output dp_status_t         status_o,
  output logic [PIXEL_W-1:0] pixel_value_o,
  output logic               stored_o
);

  localparam int unsigned LIN_W   = COORD_W + SURF_W + 1;
  localparam int unsigned RIGHT_W = CLIP_W + 1;
  localparam int unsigned SUM_W   = 2 * CHAN_W;

  // Divide by 255 with rounding already folded into the sum; exact for sums
  // below 65280, and the largest blend sum is 255 * 255 + 127.
  function automatic logic [CHAN_W-1:0] div255(input logic [SUM_W-1:0] s);
    logic [SUM_W:0] t;
    t = (SUM_W+1)'(s) + (SUM_W+1)'(s[SUM_W-1:CHAN_W]) + (SUM_W+1)'(1);
    return t[SUM_W-1:CHAN_W];
  endfunction

  logic [PIXEL_W-1:0] mem_q [STORE_DEPTH];

  logic               act_q;
  logic [COORD_W-1:0] x_q, y_q;
  logic [PIXEL_W-1:0] colour_q;
  logic [ALPHA_W-1:0] alpha_q;
  logic [ADDR_W-1:0]  addr_q;
  logic               on_surf_q, in_clip_q;
  logic [PIXEL_W-1:0] rd_q;
  logic [SUM_W-1:0]   sum_q [NUM_CHAN];
  logic [PIXEL_W-1:0] pix_q;
  logic               stored_q;

  logic [SURF_W-1:0]  eff_w, eff_h;
  logic [LIN_W-1:0]   lin;
  logic [RIGHT_W-1:0] clip_right, clip_bottom;
  logic               on_surf_d, in_clip_d;
  logic [ALPHA_W-1:0] inv_alpha;
  logic [SUM_W-1:0]   sum_d [NUM_CHAN];
  logic [PIXEL_W-1:0] blend_val;
  logic [PIXEL_W-1:0] pix_d;
  logic               stored_d;

  assign status_o.need_read  = (act_q == ACT_READ) || (alpha_q != FULL_ALPHA);
  assign status_o.need_blend = (act_q == ACT_WRITE) && (alpha_q != FULL_ALPHA);

  // Surface size saturates at the memory's row and column limits.
  always_comb begin
    eff_w = (int'(cfg_i.surface_width) > MAX_WIDTH) ? SURF_W'(MAX_WIDTH)
                                                    : cfg_i.surface_width;
    eff_h = (int'(cfg_i.surface_height) > MAX_HEIGHT) ? SURF_W'(MAX_HEIGHT)
                                                      : cfg_i.surface_height;
    on_surf_d = (eff_w != '0) && (eff_h != '0) && (x_q < eff_w) && (y_q < eff_h);

    clip_right  = RIGHT_W'(cfg_i.clip_left) + RIGHT_W'(cfg_i.clip_width);
    clip_bottom = RIGHT_W'(cfg_i.clip_top) + RIGHT_W'(cfg_i.clip_height);
    in_clip_d = (x_q >= cfg_i.clip_left) && (y_q >= cfg_i.clip_top) &&
                (RIGHT_W'(x_q) < clip_right) && (RIGHT_W'(y_q) < clip_bottom);

    // The address only matters on the surface, where it stays below the
    // memory depth, so no wrap is needed.
    lin = LIN_W'(y_q) * LIN_W'(eff_w) + LIN_W'(x_q);
  end

  assign inv_alpha = FULL_ALPHA - alpha_q;

  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
    logic [CHAN_W-1:0] over_c, under_c;
    assign over_c   = colour_q[c*CHAN_W +: CHAN_W];
    assign under_c  = rd_q[c*CHAN_W +: CHAN_W];
    assign sum_d[c] = SUM_W'(over_c) * SUM_W'(alpha_q)
                    + SUM_W'(under_c) * SUM_W'(inv_alpha)
                    + SUM_W'(ROUND_HALF);
    assign blend_val[c*CHAN_W +: CHAN_W] = div255(sum_q[c]);
  end

  always_comb begin
    pix_d    = '0;
    stored_d = 1'b0;
    if (act_q == ACT_READ) begin
      if (on_surf_q) begin
        pix_d = rd_q;
      end
    end else if (on_surf_q && in_clip_q) begin
      pix_d    = (alpha_q == FULL_ALPHA) ? colour_q : blend_val;
      stored_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q    <= action_i;
      x_q      <= x_position_i;
      y_q      <= y_position_i;
      colour_q <= colour_i;
      alpha_q  <= alpha_i;
    end
    if (cmd_i.calc) begin
      addr_q    <= ADDR_W'(lin);
      on_surf_q <= on_surf_d;
      in_clip_q <= in_clip_d;
    end
    if (cmd_i.mix) begin
      sum_q <= sum_d;
    end
    if (cmd_i.commit) begin
      pix_q    <= pix_d;
      stored_q <= stored_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_rd) begin
      rd_q <= mem_q[addr_q];
    end
    if (cmd_i.commit && stored_d) begin
      mem_q[addr_q] <= pix_d;
    end
  end

  assign pixel_value_o = pix_q;
  assign stored_o      = stored_q;

endmodule

/* rtl/core/clipped_pixel_alpha_blend.sv */
// Clipped pixel store with alpha blending over a 128 x 128 RGB888 surface.
// Each request reads, writes or blends one pixel and yields exactly one result.
// A full-opacity write steps through the address and done states, a read
// adds the read state and a blend adds read and mix; the next request is
// taken only after done, which waits while an earlier result is undelivered.
// The single-port pixel memory with its registered read and the separate
// multiply stage of a blend set this sequence. A finished result sits in an
// output register, so the next request is taken while it waits. The pixel
// memory is not cleared after reset and must be written before it is read or
// blended; config writes are expected only while the block is idle.
`include "clipped_pixel_alpha_blend_defines.svh"

module clipped_pixel_alpha_blend import cpab_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  cpab_req_if.sink   req_i,
  cpab_res_if.source res_o,
  cpab_cfg_if.sink   cfg_i
);

  cfg_t       cfg_regs;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  cpab_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_wr (cfg_i),
    .regs_o (cfg_regs)
  );

  cpab_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cpab_datapath u_datapath (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .cfg_i         (cfg_regs),
    .action_i      (req_i.action),
    .x_position_i  (req_i.x_position),
    .y_position_i  (req_i.y_position),
    .colour_i      (req_i.colour),
    .alpha_i       (req_i.alpha),
    .status_o      (status),
    .pixel_value_o (res_o.pixel_value),
    .stored_o      (res_o.stored)
  );

  `CPAB_ASSERT_IMP(a_no_result_overwrite, cmd.commit, !res_o.valid || res_o.ready, "result overwritten before delivery")
  `CPAB_ASSERT_NXT(a_one_request_at_a_time, req_i.valid && req_i.ready, !req_i.ready, "request taken while busy")
  `CPAB_ASSERT_NXT(a_result_not_repeated, res_o.valid && res_o.ready && !cmd.commit, !res_o.valid, "result delivered twice")

endmodule

/* tb/clipped_pixel_alpha_blend_test.sv */
// Self-checking testbench for the clipped pixel alpha blend block.
// It drives pixel requests and register writes and checks every result against a local model.
// Depends on cpab_pkg, the channel interfaces and the clipped_pixel_alpha_blend RTL.
module clipped_pixel_alpha_blend_test import cpab_pkg::*; ();

  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned TAIL_CYCLES    = 20;

  typedef struct packed {
    action_e            action;
    logic [COORD_W-1:0] x_position;
    logic [COORD_W-1:0] y_position;
    logic [PIXEL_W-1:0] colour;
    logic [ALPHA_W-1:0] alpha;
  } pixel_req_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_value;
    logic               stored;
  } pixel_res_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #5 clk_i = ~clk_i;

  cpab_req_if req_if ();
  cpab_res_if res_if ();
  cpab_cfg_if cfg_if ();

  clipped_pixel_alpha_blend dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  // Register shadow, shared by the request generator and the pixel model.
  int unsigned surf_w  = 128;
  int unsigned surf_h  = 128;
  int unsigned clip_l  = 0;
  int unsigned clip_t  = 0;
  int unsigned clip_wd = 128;
  int unsigned clip_ht = 128;

  logic [PIXEL_W-1:0] frame_mem [STORE_DEPTH];
  bit                 painted   [STORE_DEPTH];
  logic [15:0]        fresh_coords [$];

  pixel_req_t pending_reqs [$];
  pixel_req_t in_flight;
  pixel_res_t expected_pixels [$];
  pixel_res_t want;

  int  send_gap;
  int  recv_stall;
  int  idle_cycles;
  bit  calm_tail;
  int  fail_count;
  int  reqs_accepted;
  int  results_checked;
  int  settings_run;
  int  n_reads;
  int  n_stores;
  int  n_blends;

  function automatic int unsigned eff_w();
    return (surf_w > MAX_WIDTH) ? MAX_WIDTH : surf_w;
  endfunction

  function automatic int unsigned eff_h();
    return (surf_h > MAX_HEIGHT) ? MAX_HEIGHT : surf_h;
  endfunction

  function automatic bit on_surface(input int unsigned x, input int unsigned y);
    return eff_w() != 0 && eff_h() != 0 && x < eff_w() && y < eff_h();
  endfunction

  function automatic bit in_clip(input int unsigned x, input int unsigned y);
    return x >= clip_l && y >= clip_t && x < clip_l + clip_wd && y < clip_t + clip_ht;
  endfunction

  function automatic int unsigned addr_of(input int unsigned x, input int unsigned y);
    return (y * eff_w() + x) % STORE_DEPTH;
  endfunction

  function automatic logic [CHAN_W-1:0] mix_channel(input int unsigned under,
                                                    input int unsigned over,
                                                    input int unsigned a);
    return CHAN_W'((over * a + under * (255 - a) + 127) / 255);
  endfunction

  function automatic logic [PIXEL_W-1:0] blend_colour(input logic [PIXEL_W-1:0] under,
                                                      input logic [PIXEL_W-1:0] over,
                                                      input int unsigned a);
    return {mix_channel(under[23:16], over[23:16], a),
            mix_channel(under[15:8], over[15:8], a),
            mix_channel(under[7:0], over[7:0], a)};
  endfunction

  task automatic predict_pixel_access(input pixel_req_t rq);
    pixel_res_t  res;
    int unsigned x;
    int unsigned y;
    int unsigned addr;
    x   = rq.x_position;
    y   = rq.y_position;
    res = '0;
    if (rq.action == ACT_READ) begin
      n_reads++;
      if (on_surface(x, y)) res.pixel_value = frame_mem[addr_of(x, y)];
    end else if (on_surface(x, y) && in_clip(x, y)) begin
      addr = addr_of(x, y);
      if (rq.alpha == FULL_ALPHA) begin
        res.pixel_value = rq.colour;
      end else begin
        res.pixel_value = blend_colour(frame_mem[addr], rq.colour, rq.alpha);
        n_blends++;
      end
      frame_mem[addr] = res.pixel_value;
      res.stored      = 1'b1;
      n_stores++;
    end
    expected_pixels.push_back(res);
  endtask

  // A read or a blend of a pixel that was never written is turned into a plain
  // write, so that the stored contents are always defined.
  function automatic pixel_req_t guard_unwritten(input pixel_req_t rq);
    int unsigned x;
    int unsigned y;
    int unsigned addr;
    x = rq.x_position;
    y = rq.y_position;
    if (on_surface(x, y)) begin
      addr = addr_of(x, y);
      if (!painted[addr] &&
          (rq.action == ACT_READ || (in_clip(x, y) && rq.alpha != FULL_ALPHA))) begin
        rq.action = ACT_WRITE;
        rq.alpha  = FULL_ALPHA;
      end
      if (rq.action == ACT_WRITE && in_clip(x, y)) begin
        painted[addr] = 1'b1;
        fresh_coords.push_back({rq.x_position, rq.y_position});
      end
    end
    return rq;
  endfunction

  task automatic queue_access(input action_e act, input int unsigned x, input int unsigned y,
                              input logic [PIXEL_W-1:0] colour, input int unsigned alpha);
    pixel_req_t rq;
    rq.action     = act;
    rq.x_position = COORD_W'(x);
    rq.y_position = COORD_W'(y);
    rq.colour     = colour;
    rq.alpha      = ALPHA_W'(alpha);
    pending_reqs.push_back(guard_unwritten(rq));
  endtask

  // Most requests land on the surface, in the clip window where the two meet,
  // half on pixels already painted in this setting; the rest are unconstrained.
  task automatic queue_random_access();
    pixel_req_t  rq;
    int unsigned w;
    int unsigned h;
    int unsigned x_hi;
    int unsigned y_hi;
    logic [15:0] xy;
    w         = eff_w();
    h         = eff_h();
    rq.colour = PIXEL_W'($urandom());
    if ($urandom_range(0, 99) < 75 && w != 0 && h != 0) begin
      if (fresh_coords.size() != 0 && $urandom_range(0, 1) == 0) begin
        xy            = fresh_coords[$urandom_range(0, fresh_coords.size() - 1)];
        rq.x_position = xy[15:8];
        rq.y_position = xy[7:0];
      end else begin
        x_hi = clip_l + clip_wd;
        y_hi = clip_t + clip_ht;
        if (x_hi > w) x_hi = w;
        if (y_hi > h) y_hi = h;
        if (clip_l < x_hi && clip_t < y_hi) begin
          rq.x_position = COORD_W'($urandom_range(clip_l, x_hi - 1));
          rq.y_position = COORD_W'($urandom_range(clip_t, y_hi - 1));
        end else begin
          rq.x_position = COORD_W'($urandom_range(0, w - 1));
          rq.y_position = COORD_W'($urandom_range(0, h - 1));
        end
      end
      rq.action = ($urandom_range(0, 2) == 0) ? ACT_READ : ACT_WRITE;
      case ($urandom_range(0, 9))
        0, 1, 2: rq.alpha = FULL_ALPHA;
        3:       rq.alpha = '0;
        default: rq.alpha = ALPHA_W'($urandom_range(1, 254));
      endcase
    end else begin
      rq.action     = $urandom_range(0, 1) ? ACT_READ : ACT_WRITE;
      rq.x_position = COORD_W'($urandom());
      rq.y_position = COORD_W'($urandom());
      rq.alpha      = ($urandom_range(0, 3) == 0) ? FULL_ALPHA : ALPHA_W'($urandom());
    end
    pending_reqs.push_back(guard_unwritten(rq));
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || req_if.valid || expected_pixels.size() != 0)
      @(posedge clk_i);
  endtask

  // Must be entered right after a rising edge; valid stays high across the six writes.
  task automatic program_geometry(input int unsigned sw, input int unsigned sh,
                                  input int unsigned cl, input int unsigned ct,
                                  input int unsigned cw, input int unsigned ch);
    cfg_idx_e    regs [6];
    int unsigned vals [6];
    regs = '{CFG_SURFACE_WIDTH, CFG_SURFACE_HEIGHT, CFG_CLIP_LEFT,
             CFG_CLIP_TOP, CFG_CLIP_WIDTH, CFG_CLIP_HEIGHT};
    vals = '{sw, sh, cl, ct, cw, ch};
    for (int i = 0; i < 6; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= regs[i];
      cfg_if.data  <= vals[i][CFG_DATA_W-1:0];
      do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
      case (regs[i])
        CFG_SURFACE_WIDTH:  surf_w  = vals[i] % 256;
        CFG_SURFACE_HEIGHT: surf_h  = vals[i] % 256;
        CFG_CLIP_LEFT:      clip_l  = vals[i] % 256;
        CFG_CLIP_TOP:       clip_t  = vals[i] % 256;
        CFG_CLIP_WIDTH:     clip_wd = vals[i] % 512;
        CFG_CLIP_HEIGHT:    clip_ht = vals[i] % 512;
        default: ;
      endcase
    end
    cfg_if.valid <= 1'b0;
  endtask

  task automatic start_setting(input int unsigned sw, input int unsigned sh,
                               input int unsigned cl, input int unsigned ct,
                               input int unsigned cw, input int unsigned ch);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    program_geometry(sw, sh, cl, ct, cw, ch);
    fresh_coords.delete();
    settings_run++;
  endtask

  // Request driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid      <= 1'b0;
      req_if.action     <= ACT_WRITE;
      req_if.x_position <= '0;
      req_if.y_position <= '0;
      req_if.colour     <= '0;
      req_if.alpha      <= '0;
      send_gap          <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        predict_pixel_access(in_flight);
        reqs_accepted++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (send_gap > 0) begin
          send_gap     <= send_gap - 1;
          req_if.valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          in_flight          = pending_reqs.pop_front();
          req_if.valid      <= 1'b1;
          req_if.action     <= in_flight.action;
          req_if.x_position <= in_flight.x_position;
          req_if.y_position <= in_flight.y_position;
          req_if.colour     <= in_flight.colour;
          req_if.alpha      <= in_flight.alpha;
          if (!calm_tail && $urandom_range(0, 4) == 0) send_gap <= $urandom_range(1, 6);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      recv_stall   <= 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_pixels.size() == 0) begin
          fail_count++;
          $display("%0t: result with no request pending, pixel_value %06h stored %0b",
                   $time, res_if.pixel_value, res_if.stored);
        end else begin
          want = expected_pixels.pop_front();
          if (res_if.pixel_value !== want.pixel_value) begin
            fail_count++;
            $display("%0t: pixel_value mismatch, expected %06h, actual %06h",
                     $time, want.pixel_value, res_if.pixel_value);
          end
          if (res_if.stored !== want.stored) begin
            fail_count++;
            $display("%0t: stored mismatch, expected %0b, actual %0b",
                     $time, want.stored, res_if.stored);
          end
          results_checked++;
        end
      end
      if (recv_stall > 0) begin
        recv_stall   <= recv_stall - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
        if (!calm_tail && $urandom_range(0, 5) == 0) recv_stall <= $urandom_range(1, 6);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_SURFACE_WIDTH;
    cfg_if.data  = '0;
    idle_cycles  = 0;
    calm_tail    = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset geometry: corners, opaque writes, blends at both alpha ends, off-surface accesses.
    settings_run = 1;
    queue_access(ACT_WRITE, 0, 0, 24'hFFFFFF, 255);
    queue_access(ACT_WRITE, 127, 127, 24'h000000, 255);
    queue_access(ACT_READ, 0, 0, 24'h000000, 0);
    queue_access(ACT_READ, 127, 127, 24'hFFFFFF, 255);
    queue_access(ACT_WRITE, 0, 0, 24'h000000, 0);
    queue_access(ACT_WRITE, 127, 127, 24'hFFFFFF, 254);
    queue_access(ACT_WRITE, 0, 0, 24'h123456, 128);
    queue_access(ACT_READ, 0, 0, 24'h000000, 0);
    queue_access(ACT_WRITE, 128, 0, 24'hABCDEF, 255);
    queue_access(ACT_WRITE, 0, 128, 24'hABCDEF, 255);
    queue_access(ACT_WRITE, 255, 255, 24'hFFFFFF, 255);
    queue_access(ACT_READ, 128, 127, 24'h000000, 0);
    queue_access(ACT_READ, 255, 255, 24'hFFFFFF, 255);
    queue_access(ACT_WRITE, 64, 1, 24'hA5A5A5, 255);
    queue_access(ACT_WRITE, 64, 1, 24'h5A5A5A, 1);
    queue_access(ACT_WRITE, 64, 1, 24'hFFFFFF, 127);
    queue_access(ACT_READ, 64, 1, 24'h000000, 0);

    // Clip window strictly inside the surface; reads ignore the window.
    start_setting(128, 128, 32, 16, 64, 80);
    queue_access(ACT_WRITE, 31, 20, 24'h112233, 255);
    queue_access(ACT_READ, 0, 0, 24'h000000, 0);
    queue_access(ACT_READ, 127, 127, 24'h000000, 0);
    queue_access(ACT_WRITE, 32, 16, 24'h445566, 255);
    queue_access(ACT_WRITE, 95, 95, 24'h778899, 255);
    queue_access(ACT_WRITE, 96, 95, 24'hAABBCC, 255);
    queue_access(ACT_WRITE, 95, 96, 24'hDDEEFF, 255);
    queue_access(ACT_WRITE, 32, 16, 24'hFF00FF, 200);
    repeat (150) queue_random_access();

    start_setting(16, 8, 0, 0, 256, 256);
    repeat (150) queue_random_access();

    // Oversized surface registers saturate at the memory size.
    start_setting(255, 200, 100, 90, 256, 256);
    repeat (150) queue_random_access();

    start_setting(0, 64, 0, 0, 128, 128);
    repeat (40) queue_random_access();

    start_setting(64, 0, 0, 0, 128, 128);
    repeat (30) queue_random_access();

    // Empty clip window at the far corner: nothing may be stored.
    start_setting(128, 128, 255, 255, 0, 0);
    repeat (40) queue_random_access();

    start_setting(1, 1, 0, 0, 1, 1);
    repeat (60) queue_random_access();

    start_setting(128, 128, 0, 0, 128, 128);
    repeat (300) queue_random_access();

    start_setting(100, 77, 5, 3, 90, 70);
    calm_tail = 1'b1;
    repeat (150) queue_random_access();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_pixels.size() != 0) begin
      fail_count++;
      $display("%0t: %0d results never arrived", $time, expected_pixels.size());
    end
    $display("Checked %0d results for %0d requests across %0d register settings.",
             results_checked, reqs_accepted, settings_run);
    $display("Requests: %0d reads, %0d stores, of which %0d blends.",
             n_reads, n_stores, n_blends);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* clipped_pixel_alpha_blend.f */
+incdir+rtl/core
rtl/core/cpab_pkg.sv
rtl/core/cpab_if.sv
rtl/core/cpab_cfg_regs.sv
rtl/core/cpab_ctrl.sv
rtl/core/cpab_datapath.sv
rtl/core/clipped_pixel_alpha_blend.sv
tb/clipped_pixel_alpha_blend_test.sv
